// File: rtl/vumnb_pkg.sv
// Package for the needle meter: shared types, constants and the force table.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package vumnb_pkg;

  localparam int MAX_CHANNELS        = 8;
  localparam int CH_W                = $clog2(MAX_CHANNELS);
  localparam int FORCE_TABLE_ENTRIES = 512;
  localparam int ROM_AW              = $clog2(FORCE_TABLE_ENTRIES);
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [24:0] ONE_Q24  = 25'd16777216;
  localparam logic [31:0] POS_INIT = 32'd16777216;
  localparam logic signed [15:0] DT_Q24 = 16'sd16777;
  localparam longint LOG_SCALE_Q24 = 64'd2404974;

  // Input function codes
  typedef enum logic [1:0] {
    FN_SAMPLE = 2'd0,
    FN_BLOCK  = 2'd1,
    FN_TICK   = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  // Config register indexes
  typedef enum logic [2:0] {
    REG_NUM_CH   = 3'd0,
    REG_PEAK_TH  = 3'd1,
    REG_SIG_TH   = 3'd2,
    REG_HOLD     = 3'd3,
    REG_STIFF    = 3'd4,
    REG_DAMP     = 3'd5,
    REG_INV_MASS = 3'd6,
    REG_SPARE    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]  num_channels;
    logic [15:0] peak_threshold;
    logic [15:0] signal_threshold;
    logic [15:0] hold_ticks;
    logic [15:0] stiffness;
    logic [15:0] damping;
    logic [9:0]  inv_mass;
  } cfg_t;

  // Queued command, already classified
  typedef struct packed {
    func_t       op;
    logic [CH_W-1:0] chan;
    logic [15:0] mag;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLK_RD,
    S_BLK_ROM,
    S_BLK_WR,
    S_BLK_CLR,
    S_T_LOAD,
    S_T_ACC,
    S_T_V,
    S_T_X,
    S_T_OUT
  } state_t;

  typedef logic [24:0] rom_t [FORCE_TABLE_ENTRIES];

  // Index of the highest active channel
  function automatic logic [CH_W-1:0] active_last(input logic [3:0] n);
    logic [CH_W-1:0] r;
    if (n == 4'd0) r = '0;
    else if (int'(n) > MAX_CHANNELS) r = CH_W'(MAX_CHANNELS - 1);
    else r = CH_W'(n - 4'd1);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sd2147483647;
    else if (v < -64'sd2147483647) r = -32'sd2147483647;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [24:0] clamp_unit(input logic signed [31:0] v);
    logic [24:0] r;
    if (v < 0) r = '0;
    else if (v > $signed({7'd0, ONE_Q24})) r = ONE_Q24;
    else r = v[24:0];
    return r;
  endfunction

  // Fraction of log2(1+m/32) in Q24 by repeated squaring
  function automatic longint log2_frac(input int m);
    logic [63:0] y;
    longint r;
    y = 64'(32 + m) << 25;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        r = r | (64'sd1 <<< b);
      end
    end
    return r;
  endfunction

  // Scaled arctangent, CORDIC in vectoring mode
  function automatic longint atan_scaled(input longint t);
    longint arc [16];
    longint x, y, z, dx, dy;
    arc = '{8388608, 4952084, 2616546, 1328199, 666677, 333664, 166872, 83441,
            41721, 20861, 10430, 5215, 2608, 1304, 652, 326};
    x = 64'sd16777216;
    y = t;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + arc[i];
      end else if (y < 0) begin
        x = x - dx; y = y + dy; z = z - arc[i];
      end
    end
    return z;
  endfunction

  function automatic longint clamp_q24(input longint v);
    longint r;
    if (v < 0) r = 0;
    else if (v > 64'sd16777216) r = 64'sd16777216;
    else r = v;
    return r;
  endfunction

  function automatic logic [24:0] force_entry(input int i);
    longint e, l, f, t;
    e = longint'(i >> 5);
    if (e > 15) e = 15;
    l = (e - 15) * 64'sd16777216 + log2_frac(i & 31);
    f = clamp_q24(64'sd16777216 + ((l * LOG_SCALE_Q24) >>> 24));
    t = 2 * f - 64'sd16777216;
    return 25'(clamp_q24(64'sd8388608 + atan_scaled(t)));
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < FORCE_TABLE_ENTRIES; i++) r[i] = force_entry(i);
    return r;
  endfunction

  localparam rom_t FORCE_ROM = build_rom();

endpackage

`default_nettype wire

// File: rtl/vumnb_front.sv
// Front end: accepts input transactions, drops unused codes, forms the
// sample magnitude and holds commands in a short queue. Uses vumnb_pkg.
`default_nettype none

module vumnb_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          func,
  input  wire logic [2:0]          chan,
  input  wire logic signed [15:0]  sample,
  output logic                     q_valid,
  output vumnb_pkg::cmd_t          q_item,
  input  wire logic                q_pop
);

  localparam int PW = $clog2(vumnb_pkg::QUEUE_DEPTH);

  vumnb_pkg::cmd_t slots [vumnb_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count, count_next;
  vumnb_pkg::cmd_t cmd_in;
  logic            take, push;

  // Classify the incoming transaction
  always_comb begin
    cmd_in.op   = vumnb_pkg::func_t'(func);
    cmd_in.chan = chan;
    cmd_in.mag  = sample[15] ? 16'(~sample + 16'sd1) : sample;
  end

  assign in_ready = (count != (PW+1)'(vumnb_pkg::QUEUE_DEPTH));
  assign take     = in_valid && in_ready;
  assign push     = take && (cmd_in.op != vumnb_pkg::FN_NONE);
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) count_next = count + 1'b1;
    else if (!push && q_pop) count_next = count - 1'b1;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= PW'((int'(wr_ptr) + 1) % vumnb_pkg::QUEUE_DEPTH);
      if (q_pop) rd_ptr <= PW'((int'(rd_ptr) + 1) % vumnb_pkg::QUEUE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cmd_in;
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(vumnb_pkg::QUEUE_DEPTH)) else $error("queue overfilled");
`endif

endmodule

`default_nettype wire

// File: rtl/vumnb_back.sv
// Back end: per-channel meter state, block-end force lookup and the
// needle Euler step sequencer with its output register. Uses vumnb_pkg.
`default_nettype none

module vumnb_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire vumnb_pkg::cfg_t cfg,
  input  wire logic            q_valid,
  input  wire vumnb_pkg::cmd_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [2:0]           out_chan,
  output logic [24:0]          deflection,
  output logic                 signal_lit,
  output logic                 peak_lit,
  output logic                 last
);

  localparam int NC = vumnb_pkg::MAX_CHANNELS;
  localparam int CW = vumnb_pkg::CH_W;

  vumnb_pkg::state_t state, state_next;

  // Per-channel state
  logic [15:0]        peak   [NC];
  logic [24:0]        force_q[NC];
  logic signed [31:0] pos    [NC];
  logic signed [31:0] vel    [NC];
  logic [15:0]        hold   [NC];
  logic               sflag  [NC];

  logic [CW-1:0] ch, n_last, rd_addr;
  logic          ch_last, slot_free, emit, blk_wr;
  logic [15:0]   peak_rd;

  // Work registers
  logic [15:0]        p_r;
  logic [vumnb_pkg::ROM_AW-1:0] idx_r;
  logic               zero_r;
  logic [24:0]        rom_lo_r, rom_hi_r;
  logic signed [31:0] xc_r, vc_r, vn_r, xn_r;
  logic [28:0]        kx_r;
  logic signed [36:0] dv_r;
  logic signed [49:0] acc_r;

  assign n_last    = vumnb_pkg::active_last(cfg.num_channels);
  assign ch_last   = (ch == n_last);
  assign slot_free = !out_valid || out_ready;
  assign rd_addr   = (state == vumnb_pkg::S_IDLE) ? q_item.chan : ch;
  assign peak_rd   = peak[rd_addr];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      vumnb_pkg::S_IDLE: begin
        if (q_valid) begin
          if (q_item.op == vumnb_pkg::FN_BLOCK) state_next = vumnb_pkg::S_BLK_RD;
          else if (q_item.op == vumnb_pkg::FN_TICK) state_next = vumnb_pkg::S_T_LOAD;
        end
      end
      vumnb_pkg::S_BLK_RD:  state_next = vumnb_pkg::S_BLK_ROM;
      vumnb_pkg::S_BLK_ROM: state_next = vumnb_pkg::S_BLK_WR;
      vumnb_pkg::S_BLK_WR:
        state_next = ch_last ? vumnb_pkg::S_BLK_CLR : vumnb_pkg::S_BLK_RD;
      vumnb_pkg::S_BLK_CLR: state_next = vumnb_pkg::S_IDLE;
      vumnb_pkg::S_T_LOAD:  state_next = vumnb_pkg::S_T_ACC;
      vumnb_pkg::S_T_ACC:   state_next = vumnb_pkg::S_T_V;
      vumnb_pkg::S_T_V:     state_next = vumnb_pkg::S_T_X;
      vumnb_pkg::S_T_X:     state_next = vumnb_pkg::S_T_OUT;
      vumnb_pkg::S_T_OUT: begin
        if (slot_free) state_next = ch_last ? vumnb_pkg::S_IDLE : vumnb_pkg::S_T_LOAD;
      end
      default: state_next = vumnb_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop  = (state == vumnb_pkg::S_IDLE) && q_valid;
    emit   = (state == vumnb_pkg::S_T_OUT) && slot_free;
    blk_wr = (state == vumnb_pkg::S_BLK_WR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vumnb_pkg::S_IDLE;
      ch    <= '0;
    end else begin
      state <= state_next;
      if (state == vumnb_pkg::S_IDLE) ch <= '0;
      else if ((blk_wr || emit) && !ch_last) ch <= ch + 1'b1;
    end
  end

  // Block end: leading-one exponent and mantissa to table index
  logic [3:0]  lo_pos;
  logic [20:0] mant_sh;
  logic [vumnb_pkg::ROM_AW:0] idx_full;
  always_comb begin
    lo_pos = '0;
    for (int i = 0; i < 16; i++) begin
      if (peak_rd[i]) lo_pos = 4'(i);
    end
    mant_sh  = {peak_rd, 5'd0} >> lo_pos;
    idx_full = {1'b0, lo_pos, mant_sh[4:0]};
    if (int'(idx_full) >= vumnb_pkg::FORCE_TABLE_ENTRIES)
      idx_full = (vumnb_pkg::ROM_AW+1)'(vumnb_pkg::FORCE_TABLE_ENTRIES - 1);
  end

  // Needle step arithmetic
  logic signed [31:0] x_in, v_in, xc, vc;
  logic [40:0]        kx_prod;
  logic signed [48:0] dv_prod, dv_sh;
  logic signed [38:0] diff;
  logic signed [49:0] acc_prod;
  logic signed [65:0] av, av_sh;
  logic signed [63:0] vsum, xsum;
  logic signed [47:0] xv, xv_sh;
  always_comb begin
    x_in = pos[ch];
    v_in = vel[ch];
    xc   = x_in;
    vc   = v_in;
    if (x_in < 0) begin
      xc = '0;
      if (v_in < 0) vc = -v_in;
    end else if (x_in > $signed(vumnb_pkg::POS_INIT)) begin
      xc = $signed(vumnb_pkg::POS_INIT);
      if (v_in > 0) vc = -v_in;
    end
    kx_prod  = cfg.stiffness * xc[24:0];
    dv_prod  = $signed({1'b0, cfg.damping}) * vc;
    dv_sh    = dv_prod >>> 12;
    diff     = $signed({14'd0, force_q[ch]}) - $signed({10'd0, kx_r})
             - $signed({{2{dv_r[36]}}, dv_r});
    acc_prod = diff * $signed({1'b0, cfg.inv_mass});
    av       = acc_r * vumnb_pkg::DT_Q24;
    av_sh    = av >>> 24;
    vsum     = $signed({{32{vc_r[31]}}, vc_r}) + $signed(av_sh[63:0]);
    xv       = vn_r * vumnb_pkg::DT_Q24;
    xv_sh    = xv >>> 24;
    xsum     = $signed({{32{xc_r[31]}}, xc_r}) + $signed({{16{xv_sh[47]}}, xv_sh});
  end

  // Work registers
  always_ff @(posedge clk) begin
    if (state == vumnb_pkg::S_BLK_RD) begin
      p_r    <= peak_rd;
      idx_r  <= idx_full[vumnb_pkg::ROM_AW-1:0];
      zero_r <= (peak_rd == '0);
    end
    if (state == vumnb_pkg::S_BLK_ROM) begin
      rom_lo_r <= vumnb_pkg::FORCE_ROM[{1'b0, idx_r[vumnb_pkg::ROM_AW-2:0]}];
      rom_hi_r <= vumnb_pkg::FORCE_ROM[{1'b1, idx_r[vumnb_pkg::ROM_AW-2:0]}];
    end
    if (state == vumnb_pkg::S_T_LOAD) begin
      xc_r <= xc;
      vc_r <= vc;
      kx_r <= kx_prod[40:12];
      dv_r <= dv_sh[36:0];
    end
    if (state == vumnb_pkg::S_T_ACC) acc_r <= acc_prod;
    if (state == vumnb_pkg::S_T_V)   vn_r  <= vumnb_pkg::sat32(vsum);
    if (state == vumnb_pkg::S_T_X)   xn_r  <= vumnb_pkg::sat32(xsum);
  end

  // Channel state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NC; c++) begin
        peak[c]    <= '0;
        force_q[c] <= '0;
        pos[c]     <= $signed(vumnb_pkg::POS_INIT);
        vel[c]     <= '0;
        hold[c]    <= '0;
        sflag[c]   <= 1'b0;
      end
    end else begin
      if (q_pop && q_item.op == vumnb_pkg::FN_SAMPLE && q_item.mag > peak_rd)
        peak[q_item.chan] <= q_item.mag;
      if (blk_wr) begin
        force_q[ch] <= zero_r ? '0 : (idx_r[vumnb_pkg::ROM_AW-1] ? rom_hi_r : rom_lo_r);
        sflag[ch]   <= (p_r > cfg.signal_threshold);
        if (p_r > cfg.peak_threshold) hold[ch] <= cfg.hold_ticks;
      end
      if (state == vumnb_pkg::S_BLK_CLR) begin
        for (int c = 0; c < NC; c++) peak[c] <= '0;
      end
      if (emit) begin
        pos[ch] <= xn_r;
        vel[ch] <= vn_r;
        if (hold[ch] != '0) hold[ch] <= hold[ch] - 16'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_chan   <= 3'(ch);
      deflection <= vumnb_pkg::clamp_unit(xn_r);
      signal_lit <= sflag[ch];
      peak_lit   <= (hold[ch] != '0);
      last       <= ch_last;
    end
  end

`ifndef ASSERT_OFF
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    (state != vumnb_pkg::S_IDLE) |-> (ch <= n_last)) else $error("channel past active range");
  a_last_chan: assert property (@(posedge clk) disable iff (rst)
    emit |=> (last == (out_chan == 3'(n_last)))) else $error("last flag mismatch");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == vumnb_pkg::S_IDLE)) else $error("pop while busy");
`endif

endmodule

`default_nettype wire

// File: rtl/vu_meter_needle_ballistics.sv
// Multichannel needle meter, top level.
// Ports: input channel (func, chan, sample) with in_valid/in_ready; result
// channel (out_chan, deflection, signal_lit, peak_lit, last) with
// out_valid/out_ready; config write port cfg_we/cfg_index/cfg_data.
// Input transactions land in a two-entry command queue; in_ready drops only
// when it is full. The back end takes each command from the queue in its
// idle state; a sample needs nothing more. An end-of-block command then
// steps through each active channel (read, table lookup split into two
// halves, write) and then clears the peaks. A tick then steps each active
// channel through load, acceleration, velocity, position and emit, the
// chain of registered multiplies in the step, and gives one result per
// active channel in channel order, last set on the highest one.
// A stalled receiver holds the result register; the sequencer waits in its
// emit step and the queue keeps taking commands until it fills.
// Reset (rst, synchronous) loads default registers, empties the queue, sets
// every needle to full scale at rest and clears peaks, forces and lamps.
// Depends on vumnb_pkg, vumnb_front and vumnb_back.
`default_nettype none

module vu_meter_needle_ballistics (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic [2:0]         chan,
  input  wire logic signed [15:0] sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_chan,
  output logic [24:0]             deflection,
  output logic                    signal_lit,
  output logic                    peak_lit,
  output logic                    last,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  vumnb_pkg::cfg_t cfg;
  vumnb_pkg::cmd_t q_item;
  logic            q_valid, q_pop;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_channels     <= 4'd2;
      cfg.peak_threshold   <= 16'd27571;
      cfg.signal_threshold <= 16'd51;
      cfg.hold_ticks       <= 16'd250;
      cfg.stiffness        <= 16'd4096;
      cfg.damping          <= 16'd328;
      cfg.inv_mass         <= 10'd200;
    end else if (cfg_we) begin
      unique case (vumnb_pkg::reg_idx_t'(cfg_index))
        vumnb_pkg::REG_NUM_CH:   cfg.num_channels     <= cfg_data[3:0];
        vumnb_pkg::REG_PEAK_TH:  cfg.peak_threshold   <= cfg_data;
        vumnb_pkg::REG_SIG_TH:   cfg.signal_threshold <= cfg_data;
        vumnb_pkg::REG_HOLD:     cfg.hold_ticks       <= cfg_data;
        vumnb_pkg::REG_STIFF:    cfg.stiffness        <= cfg_data;
        vumnb_pkg::REG_DAMP:     cfg.damping          <= cfg_data;
        vumnb_pkg::REG_INV_MASS: cfg.inv_mass         <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  vumnb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .chan     (chan),
    .sample   (sample),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  vumnb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_chan   (out_chan),
    .deflection (deflection),
    .signal_lit (signal_lit),
    .peak_lit   (peak_lit),
    .last       (last)
  );

endmodule

`default_nettype wire
